// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define CLDA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define CLDA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/clda_pkg.sv =====
package clda_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_N          = 1 << SINE_TABLE_BITS;
    localparam int QUARTER_N       = SINE_N >> 2;
    localparam int P_W             = 17;

    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint C1      = 64'sd1686629713;
    localparam longint C3      = -64'sd693598669;
    localparam longint C5      = 64'sd85569306;
    localparam longint C7      = -64'sd5026991;
    localparam longint C9      = 64'sd172272;

    // Command from the front part to the back part.
    typedef struct packed {
        logic           close;
        logic           bank;
        logic [P_W-1:0] p;
        logic           tick;
    } t_cmd;

    // Back part reports a finished period so its buffer bank can be refilled.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_done;

    typedef logic [14:0] t_qtab [QUARTER_N+1];

    // Quarter-wave sine in Q1.15, odd polynomial in Q30.
    function automatic logic [14:0] f_qsin(input int q);
        longint t;
        longint t2;
        longint p;
        longint s;
        longint r;
        t  = longint'(q) << (32 - SINE_TABLE_BITS);
        t2 = t * t / ONE_Q30;
        p  = C9;
        p  = C7 + p * t2 / ONE_Q30;
        p  = C5 + p * t2 / ONE_Q30;
        p  = C3 + p * t2 / ONE_Q30;
        p  = C1 + p * t2 / ONE_Q30;
        s  = p * t / ONE_Q30;
        r  = (s * 32767 + ONE_Q30 / 2) / ONE_Q30;
        if (r < 0) r = 0;
        if (r > 32767) r = 32767;
        return r[14:0];
    endfunction

    function automatic t_qtab f_build_qtab();
        t_qtab tab;
        for (int k = 0; k <= QUARTER_N; k++) begin
            tab[k] = f_qsin(k);
        end
        return tab;
    endfunction

    localparam t_qtab QTAB = f_build_qtab();

    // Full-turn sine from the quarter table by symmetry.
    function automatic logic signed [15:0] f_sine(input logic [SINE_TABLE_BITS-1:0] k);
        logic [1:0]                 quad;
        logic [SINE_TABLE_BITS-2:0] q;
        logic [SINE_TABLE_BITS-2:0] qi;
        logic signed [15:0]         v;
        quad = k[SINE_TABLE_BITS-1 -: 2];
        q    = {1'b0, k[SINE_TABLE_BITS-3:0]};
        qi   = quad[0] ? ((SINE_TABLE_BITS-1)'(QUARTER_N) - q) : q;
        v    = signed'({1'b0, QTAB[qi]});
        return quad[1] ? -v : v;
    endfunction

endpackage

// ===== src/clda_ram.sv =====
module clda_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/clda_div.sv =====
module clda_div #(
    parameter int DW = 33,
    parameter int VW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient,
    output logic [VW-1:0] o_remainder
);

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quo;
    logic [VW-1:0]   r_rem;
    logic [VW-1:0]   r_div;
    logic [VW:0]     sh;
    logic            fit;

    assign sh  = {r_rem, r_quo[DW-1]};
    assign fit = (sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle, restoring form.
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fit};
            r_rem <= fit ? VW'(sh - {1'b0, r_div}) : VW'(sh);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== src/clda_cmd_fifo.sv =====
`include "assert_macros.svh"

module clda_cmd_fifo
    import clda_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `CLDA_ASSERT_NEXT(a_fifo_count_up, i_clk, i_rst_n, do_push && !do_pop,
        r_count == $past(r_count) + 1'b1, "command queue count did not advance")

endmodule

// ===== src/clda_front.sv =====
`include "assert_macros.svh"

module clda_front
    import clda_pkg::*;
#(
    parameter int MAX_PERIOD = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic signed [15:0]                i_sig_sample,
    input  logic signed [15:0]                i_ref_sample,
    input  logic [19:0]                       i_interval,
    output logic                              o_st_we,
    output logic [$clog2(2*MAX_PERIOD)-1:0]   o_st_waddr,
    output logic [15:0]                       o_st_wdata,
    output logic                              o_cmd_push,
    output t_cmd                              o_cmd,
    input  logic                              i_cmd_full,
    input  t_done                             i_done
);

    localparam int CW  = $clog2(MAX_PERIOD + 2);
    localparam int SAW = $clog2(2 * MAX_PERIOD);

    logic          r_ref_neg;
    logic          r_locked;
    logic [CW-1:0] r_cnt;
    logic          r_bank;
    logic [1:0]    r_busy;
    logic [19:0]   r_tick;

    logic          accept;
    logic          neg;
    logic          rise;
    logic [CW-1:0] cnt_next;
    logic          close;
    logic [20:0]   tick_inc;
    logic [19:0]   interval;
    logic          tick;

    assign o_full   = i_cmd_full || r_busy[r_bank];
    assign accept   = i_push && !o_full;
    assign neg      = i_ref_sample[15];
    assign rise     = r_ref_neg && !neg;
    assign cnt_next = (r_cnt <= CW'(MAX_PERIOD)) ? r_cnt + 1'b1 : r_cnt;
    assign close    = r_locked && rise && (cnt_next <= CW'(MAX_PERIOD));
    assign interval = (i_interval == '0) ? 20'd1 : i_interval;
    assign tick_inc = {1'b0, r_tick} + 21'd1;
    assign tick     = (tick_inc >= {1'b0, interval});

    assign o_st_we    = accept && r_locked && (r_cnt < CW'(MAX_PERIOD));
    assign o_st_waddr = r_bank ? SAW'(MAX_PERIOD) + SAW'(r_cnt) : SAW'(r_cnt);
    assign o_st_wdata = i_sig_sample;

    assign o_cmd_push = accept && (close || tick);
    assign o_cmd.close = close;
    assign o_cmd.bank  = r_bank;
    assign o_cmd.p     = P_W'(cnt_next);
    assign o_cmd.tick  = tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_neg <= 1'b0;
            r_locked  <= 1'b0;
            r_cnt     <= '0;
            r_bank    <= 1'b0;
            r_busy    <= '0;
            r_tick    <= '0;
        end else begin
            if (i_done.valid) begin
                r_busy[i_done.bank] <= 1'b0;
            end
            if (accept) begin
                r_ref_neg <= neg;
                r_tick    <= tick ? '0 : tick_inc[19:0];
                if (!r_locked) begin
                    if (rise) begin
                        r_locked <= 1'b1;
                        r_cnt    <= '0;
                    end
                end else begin
                    // drop an overlong period at its closing edge
                    r_cnt <= rise ? '0 : cnt_next;
                    if (close) begin
                        r_busy[r_bank] <= 1'b1;
                        r_bank         <= ~r_bank;
                    end
                end
            end
        end
    end

    `CLDA_ASSERT_NEXT(a_close_flips_bank, i_clk, i_rst_n, o_cmd_push && close,
        (r_bank != $past(r_bank)) && (r_cnt == '0), "closed period did not switch bank")

endmodule

// ===== src/clda_back.sv =====
`include "assert_macros.svh"

module clda_back
    import clda_pkg::*;
#(
    parameter int MAX_PERIOD = 1024,
    parameter int WINDOW_MAX = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_empty,
    output logic                            o_cmd_pop,
    input  t_cmd                            i_cmd,
    output logic [$clog2(2*MAX_PERIOD)-1:0] o_st_raddr,
    input  logic [15:0]                     i_st_rdata,
    input  logic [15:0]                     i_phase_offset,
    input  logic [16:0]                     i_window_length,
    input  logic                            i_win_clear,
    output t_done                           o_done,
    output logic                            o_empty,
    input  logic                            i_pop,
    output logic signed [15:0]              o_x_mean,
    output logic signed [15:0]              o_y_mean
);

    localparam int SAW = $clog2(2 * MAX_PERIOD);
    localparam int PTW = $clog2(WINDOW_MAX);
    localparam int LW  = $clog2(WINDOW_MAX + 1);
    localparam int SW  = 17 + PTW;
    localparam int VW  = (LW > P_W) ? LW : P_W;
    localparam int OW  = LW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIVP = 4'd1;
    localparam logic [3:0] S_PA   = 4'd2;
    localparam logic [3:0] S_PB   = 4'd3;
    localparam logic [3:0] S_PC   = 4'd4;
    localparam logic [3:0] S_TICK = 4'd5;
    localparam logic [3:0] S_DX   = 4'd6;
    localparam logic [3:0] S_YST  = 4'd7;
    localparam logic [3:0] S_DY   = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    logic [3:0]           r_state;
    logic [3:0]           n_state;
    t_cmd                 r_cmd;
    logic [16:0]          r_q;
    logic [P_W-1:0]       r_r;
    logic [16:0]          r_acc;
    logic [P_W-1:0]       r_rem;
    logic [P_W-1:0]       r_j;
    logic signed [15:0]   r_sin;
    logic signed [15:0]   r_cos;
    logic signed [31:0]   r_px;
    logic signed [31:0]   r_py;
    logic [31:0]          r_old;
    logic [PTW-1:0]       r_ptr;
    logic [LW-1:0]        r_fill;
    logic signed [SW-1:0] r_xsum;
    logic signed [SW-1:0] r_ysum;
    logic                 r_neg;
    logic [15:0]          r_mx;
    logic [15:0]          r_my;
    logic                 r_ovalid;
    logic [15:0]          r_ox;
    logic [15:0]          r_oy;

    logic [LW-1:0]              eff_l;
    logic                       full_win;
    logic [15:0]                ang;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-1:0] cidx;
    logic [P_W:0]               rem_sum;
    logic                       rem_wrap;
    logic [OW-1:0]              ptr_e;
    logic [OW-1:0]              len_e;
    logic [OW-1:0]              old_a;
    logic [PTW-1:0]             win_raddr;
    logic [31:0]                win_rdata;
    logic                       win_we;
    logic signed [31:0]         xr;
    logic signed [31:0]         yr;
    logic signed [15:0]         xv;
    logic signed [15:0]         yv;
    logic signed [SW-1:0]       old_x;
    logic signed [SW-1:0]       old_y;
    logic                       last_pair;
    logic                       div_start;
    logic [SW-1:0]              div_dvd;
    logic [VW-1:0]              div_dvs;
    logic                       div_done;
    logic [SW-1:0]              div_quo;
    logic [VW-1:0]              div_rem;
    logic signed [SW-1:0]       msum;
    logic [SW-1:0]              mag;
    logic [15:0]                mval;

    always_comb begin
        if (i_window_length == '0) begin
            eff_l = LW'(1);
        end else if (32'(i_window_length) > 32'(WINDOW_MAX)) begin
            eff_l = LW'(WINDOW_MAX);
        end else begin
            eff_l = LW'(i_window_length);
        end
    end

    assign full_win = (r_fill >= eff_l);

    // angle j*65536/p advanced by quotient and remainder of 65536/p
    assign ang      = r_acc[15:0] + i_phase_offset;
    assign idx      = ang[15 -: SINE_TABLE_BITS];
    assign cidx     = idx + SINE_TABLE_BITS'(QUARTER_N);
    assign rem_sum  = {1'b0, r_rem} + {1'b0, r_r};
    assign rem_wrap = (rem_sum >= {1'b0, r_cmd.p});

    assign o_st_raddr = r_cmd.bank ? SAW'(MAX_PERIOD) + SAW'(r_j) : SAW'(r_j);

    // oldest pair that leaves the window
    assign ptr_e     = OW'(r_ptr);
    assign len_e     = OW'(eff_l);
    assign old_a     = (ptr_e >= len_e) ? ptr_e - len_e : ptr_e + OW'(WINDOW_MAX) - len_e;
    assign win_raddr = PTW'(old_a);
    assign win_we    = (r_state == S_PC);

    assign xr    = (r_px + 32'sd16384) >>> 15;
    assign yr    = (r_py + 32'sd16384) >>> 15;
    assign xv    = xr[15:0];
    assign yv    = yr[15:0];
    assign old_x = SW'(signed'(r_old[31:16]));
    assign old_y = SW'(signed'(r_old[15:0]));

    assign last_pair = (r_j + 1'b1 == r_cmd.p);

    clda_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_MAX)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_ptr),
        .i_wdata ({xv, yv}),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    assign msum = (r_state == S_YST) ? r_ysum : r_xsum;
    assign mag  = msum[SW-1] ? SW'(-msum) : SW'(msum);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = SW'(32'd65536);
        div_dvs   = VW'(i_cmd.p);
        if (r_state == S_IDLE) begin
            div_start = !i_cmd_empty && i_cmd.close;
        end else begin
            div_start = ((r_state == S_TICK) && full_win) || (r_state == S_YST);
            div_dvd   = mag + SW'(eff_l >> 1);
            div_dvs   = VW'(eff_l);
        end
    end

    clda_div #(
        .DW (SW),
        .VW (VW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign mval = r_neg ? 16'(-div_quo[15:0]) : div_quo[15:0];

    assign o_cmd_pop    = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_done.valid = (r_state == S_PC) && last_pair;
    assign o_done.bank  = r_cmd.bank;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    n_state = i_cmd.close ? S_DIVP : S_TICK;
                end
            end
            S_DIVP: begin
                if (div_done) begin
                    n_state = S_PA;
                end
            end
            S_PA: n_state = S_PB;
            S_PB: n_state = S_PC;
            S_PC: begin
                if (last_pair) begin
                    n_state = r_cmd.tick ? S_TICK : S_IDLE;
                end else begin
                    n_state = S_PA;
                end
            end
            S_TICK: n_state = full_win ? S_DX : S_IDLE;
            S_DX: begin
                if (div_done) begin
                    n_state = S_YST;
                end
            end
            S_YST: n_state = S_DY;
            S_DY: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_fill   <= '0;
            r_xsum   <= '0;
            r_ysum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            if (i_win_clear) begin
                r_fill <= '0;
                r_xsum <= '0;
                r_ysum <= '0;
            end else if (r_state == S_PC) begin
                if (full_win) begin
                    r_xsum <= r_xsum - old_x + SW'(xv);
                    r_ysum <= r_ysum - old_y + SW'(yv);
                end else begin
                    r_fill <= r_fill + 1'b1;
                    r_xsum <= r_xsum + SW'(xv);
                    r_ysum <= r_ysum + SW'(yv);
                end
                r_ptr <= (r_ptr == PTW'(WINDOW_MAX - 1)) ? '0 : r_ptr + 1'b1;
            end
            if ((r_state == S_OUT) && !r_ovalid) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    r_cmd <= i_cmd;
                end
            end
            S_DIVP: begin
                r_q   <= div_quo[16:0];
                r_r   <= P_W'(div_rem);
                r_acc <= '0;
                r_rem <= '0;
                r_j   <= '0;
            end
            S_PA: begin
                r_sin <= f_sine(idx);
                r_cos <= f_sine(cidx);
                if (rem_wrap) begin
                    r_acc <= r_acc + r_q + 17'd1;
                    r_rem <= P_W'(rem_sum - {1'b0, r_cmd.p});
                end else begin
                    r_acc <= r_acc + r_q;
                    r_rem <= P_W'(rem_sum);
                end
            end
            S_PB: begin
                r_px  <= signed'(i_st_rdata) * r_sin;
                r_py  <= signed'(i_st_rdata) * r_cos;
                r_old <= win_rdata;
            end
            S_PC: begin
                r_j <= r_j + 1'b1;
            end
            S_TICK: begin
                r_neg <= r_xsum[SW-1];
            end
            S_DX: begin
                if (div_done) begin
                    r_mx <= mval;
                end
            end
            S_YST: begin
                r_neg <= r_ysum[SW-1];
            end
            S_DY: begin
                if (div_done) begin
                    r_my <= mval;
                end
            end
            S_OUT: begin
                // hold the waiting result until it is popped
                if (!r_ovalid) begin
                    r_ox <= r_mx;
                    r_oy <= r_my;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_empty  = !r_ovalid;
    assign o_x_mean = r_ox;
    assign o_y_mean = r_oy;

    `CLDA_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= eff_l,
        "window fill exceeds window length")
    `CLDA_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_OUT) && !r_ovalid,
        r_ovalid && (r_state == S_IDLE), "result not loaded into output register")

endmodule

// ===== src/chopper_lockin_demodulator_top.sv =====
// Channel   Direction  Handshake                        Payload
// input     in         push / full                      i_sig_sample, i_ref_sample
// result    out        empty / pop                      o_x_mean, o_y_mean
// config    in         i_cfg_valid / o_cfg_ready        i_cfg_index, i_cfg_data
//
// The front part takes one sample per cycle, while full is low, into a double-banked
// period buffer. A closed period of P samples first runs the angle-step divider, then
// each sample passes through buffer read, multiply and window update in the back part.
// An output tick with a full window runs the x and y mean divisions in turn
// in the shared serial divider. The front fills one bank while the back reads the other.
// Reset is synchronous, active low; no clearing pass is needed.
// full rises when the command queue fills or the next buffer bank is still being read.
module chopper_lockin_demodulator_top
    import clda_pkg::*;
#(
    parameter int MAX_PERIOD = 1024,
    parameter int WINDOW_MAX = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_sig_sample,
    input  logic signed [15:0] i_ref_sample,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] o_x_mean,
    output logic signed [15:0] o_y_mean,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [19:0]        i_cfg_data
);

    localparam logic [1:0] CFG_PHASE    = 2'd0;
    localparam logic [1:0] CFG_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam int SAW = $clog2(2 * MAX_PERIOD);

    logic [15:0] r_phase_offset;
    logic [16:0] r_window_length;
    logic [19:0] r_interval;
    logic        cfg_wr;
    logic        win_clear;

    logic           st_we;
    logic [SAW-1:0] st_waddr;
    logic [15:0]    st_wdata;
    logic [SAW-1:0] st_raddr;
    logic [15:0]    st_rdata;
    logic           cmd_push;
    t_cmd           cmd_in;
    logic           cmd_full;
    logic           cmd_pop;
    t_cmd           cmd_out;
    logic           cmd_empty;
    t_done          done;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign win_clear   = cfg_wr && (i_cfg_index == CFG_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_offset  <= '0;
            r_window_length <= 17'd65536;
            r_interval      <= 20'd24000;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_PHASE:    r_phase_offset  <= i_cfg_data[15:0];
                CFG_LENGTH:   r_window_length <= i_cfg_data[16:0];
                CFG_INTERVAL: r_interval      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    clda_front #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_sig_sample (i_sig_sample),
        .i_ref_sample (i_ref_sample),
        .i_interval   (r_interval),
        .o_st_we      (st_we),
        .o_st_waddr   (st_waddr),
        .o_st_wdata   (st_wdata),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in),
        .i_cmd_full   (cmd_full),
        .i_done       (done)
    );

    clda_ram #(
        .WIDTH (16),
        .DEPTH (2 * MAX_PERIOD)
    ) u_period_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    clda_cmd_fifo #(
        .DEPTH (4)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    clda_back #(
        .MAX_PERIOD (MAX_PERIOD),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_empty     (cmd_empty),
        .o_cmd_pop       (cmd_pop),
        .i_cmd           (cmd_out),
        .o_st_raddr      (st_raddr),
        .i_st_rdata      (st_rdata),
        .i_phase_offset  (r_phase_offset),
        .i_window_length (r_window_length),
        .i_win_clear     (win_clear),
        .o_done          (done),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_x_mean        (o_x_mean),
        .o_y_mean        (o_y_mean)
    );

endmodule

// ===== tb/sv/tb_chopper_lockin_demodulator_top.sv =====
`timescale 1ns / 100ps

module tb_chopper_lockin_demodulator_top;
    import clda_pkg::SINE_TABLE_BITS;
    import clda_pkg::SINE_N;
    import clda_pkg::QUARTER_N;

    localparam int MAX_PER  = 1024;
    localparam int WIN_MAX  = 65536;
    localparam int SETTLE   = 4000;

    localparam logic [1:0] REG_PHASE    = 2'd0;
    localparam logic [1:0] REG_WIN_LEN  = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [2:0] WR_PHASE    = 3'b001;
    localparam logic [2:0] WR_WIN_LEN  = 3'b010;
    localparam logic [2:0] WR_INTERVAL = 3'b100;
    localparam logic [2:0] WR_ALL      = 3'b111;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] i_sig_sample;
    logic signed [15:0] i_ref_sample;
    logic               empty;
    logic               pop;
    logic signed [15:0] o_x_mean;
    logic signed [15:0] o_y_mean;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [19:0]        i_cfg_data;

    chopper_lockin_demodulator_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_sig_sample (i_sig_sample),
        .i_ref_sample (i_ref_sample),
        .empty        (empty),
        .pop          (pop),
        .o_x_mean     (o_x_mean),
        .o_y_mean     (o_y_mean),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    typedef struct {
        shortint x;
        shortint y;
    } mean_pair_t;

    mean_pair_t mean_q[$];
    int         mismatches = 0;
    bit         hold_rx    = 1'b0;
    bit         no_stall   = 1'b0;
    bit         pressure_go = 1'b0;

    // Lock-in state mirror
    shortint    sine_tab [SINE_N];
    int unsigned cur_phase;
    int unsigned cur_wlen;
    int unsigned cur_interval;
    bit          was_neg;
    bit          is_locked;
    shortint     per_buf [MAX_PER];
    int unsigned per_cnt;
    shortint     xwin [WIN_MAX];
    shortint     ywin [WIN_MAX];
    int unsigned wptr;
    int unsigned wfill;
    longint      xacc;
    longint      yacc;
    int unsigned ticks;

    function automatic shortint quarter_wave(int q);
        longint t;
        longint t2;
        longint p;
        longint s;
        longint r;
        t  = longint'(q) << (32 - SINE_TABLE_BITS);
        t2 = t * t / 64'sd1073741824;
        p  = 64'sd172272;
        p  = -64'sd5026991 + p * t2 / 64'sd1073741824;
        p  = 64'sd85569306 + p * t2 / 64'sd1073741824;
        p  = -64'sd693598669 + p * t2 / 64'sd1073741824;
        p  = 64'sd1686629713 + p * t2 / 64'sd1073741824;
        s  = p * t / 64'sd1073741824;
        r  = (s * 32767 + 64'sd536870912) / 64'sd1073741824;
        if (r < 0) r = 0;
        if (r > 32767) r = 32767;
        return shortint'(r);
    endfunction

    function automatic shortint round_q15(longint a, longint b);
        longint p;
        p = a * b + 16384;
        return shortint'(p >>> 15);
    endfunction

    function automatic int unsigned used_len();
        if (cur_wlen == 0) return 1;
        if (cur_wlen > WIN_MAX) return WIN_MAX;
        return cur_wlen;
    endfunction

    function automatic longint rounded_mean(longint sum, int unsigned len);
        longint mag;
        longint m;
        mag = (sum < 0) ? -sum : sum;
        m = (mag + longint'(len / 2)) / longint'(len);
        return (sum < 0) ? -m : m;
    endfunction

    function automatic void window_add(shortint xv, shortint yv);
        int unsigned len;
        int unsigned old;
        len = used_len();
        if (wfill >= len) begin
            old = (wptr + WIN_MAX - len) % WIN_MAX;
            xacc -= xwin[old];
            yacc -= ywin[old];
        end else begin
            wfill++;
        end
        xwin[wptr] = xv;
        ywin[wptr] = yv;
        xacc += xv;
        yacc += yv;
        wptr = (wptr + 1) % WIN_MAX;
    endfunction

    function automatic void demod_period(int unsigned p);
        longint      ang;
        int unsigned idx;
        for (int unsigned j = 0; j < p; j++) begin
            ang = (longint'(j) * 65536) / p;
            ang = (ang + cur_phase) & 16'hFFFF;
            idx = int'(ang) >> (16 - SINE_TABLE_BITS);
            window_add(round_q15(per_buf[j], sine_tab[idx]),
                       round_q15(per_buf[j], sine_tab[(idx + QUARTER_N) % SINE_N]));
        end
    endfunction

    function automatic void lockin_reset();
        int unsigned quad;
        int unsigned q;
        shortint     v;
        for (int k = 0; k < SINE_N; k++) begin
            quad = k / QUARTER_N;
            q    = k % QUARTER_N;
            v    = quad[0] ? quarter_wave(QUARTER_N - q) : quarter_wave(q);
            sine_tab[k] = quad[1] ? -v : v;
        end
        cur_phase = 0; cur_wlen = 65536; cur_interval = 24000;
        was_neg = 0; is_locked = 0; per_cnt = 0;
        wptr = 0; wfill = 0; xacc = 0; yacc = 0; ticks = 0;
    endfunction

    function automatic void lockin_cfg(logic [1:0] idx, logic [19:0] data);
        case (idx)
            REG_PHASE: cur_phase = data[15:0];
            REG_WIN_LEN: begin
                cur_wlen = data[16:0];
                wfill = 0; xacc = 0; yacc = 0;
            end
            REG_INTERVAL: cur_interval = data;
            default: ;
        endcase
    endfunction

    function automatic bit lockin_step(shortint sig, shortint refv, output mean_pair_t res);
        bit          neg;
        bit          rise;
        int unsigned ivl;
        int unsigned len;
        neg  = refv < 0;
        rise = was_neg && !neg;
        ivl  = (cur_interval != 0) ? cur_interval : 1;
        was_neg = neg;
        if (!is_locked) begin
            if (rise) begin
                is_locked = 1;
                per_cnt = 0;
            end
        end else begin
            if (per_cnt < MAX_PER) per_buf[per_cnt] = sig;
            if (per_cnt <= MAX_PER) per_cnt++;
            if (rise) begin
                if (per_cnt <= MAX_PER) demod_period(per_cnt);
                per_cnt = 0;
            end
        end
        ticks++;
        if (ticks >= ivl) begin
            len = used_len();
            ticks = 0;
            if (wfill >= len) begin
                res.x = shortint'(rounded_mean(xacc, len));
                res.y = shortint'(rounded_mean(yacc, len));
                return 1;
            end
        end
        return 0;
    endfunction

    // Leaves valid high; the caller drops it after the last write.
    task automatic cfg_write(logic [1:0] idx, logic [19:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        lockin_cfg(idx, data);
    endtask

    task automatic apply_settings(logic [2:0] mask, int unsigned ph, int unsigned wl,
                                  int unsigned ivl);
        if (mask & WR_PHASE)    cfg_write(REG_PHASE, 20'(ph));
        if (mask & WR_WIN_LEN)  cfg_write(REG_WIN_LEN, 20'(wl));
        if (mask & WR_INTERVAL) cfg_write(REG_INTERVAL, 20'(ivl));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (mean_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Offer one sample; returns once the transaction is taken.
    task automatic send_sample(shortint sig, shortint refv, bit gapless,
                               output bit fired, output mean_pair_t res);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push         <= 1'b1;
        i_sig_sample <= sig;
        i_ref_sample <= refv;
        do @(posedge i_clk); while (full);
        fired = lockin_step(sig, refv, res);
    endtask

    task automatic random_phase(int n, bit gapless, bit force_long);
        int         sent;
        int         run_left;
        bit         neg;
        shortint    sig;
        shortint    refv;
        bit         fired;
        mean_pair_t res;
        sent = 0; run_left = 0; neg = 1'b0;
        while (sent < n || run_left > 0) begin
            if (run_left == 0) begin
                neg = ~neg;
                if (neg && (force_long || $urandom_range(0, 99) == 0)) begin
                    run_left = MAX_PER + $urandom_range(2, 8);
                    force_long = 1'b0;
                end else begin
                    run_left = $urandom_range(1, 12);
                end
            end
            run_left--;
            case ($urandom_range(0, 9))
                0: sig = 16'sh8000;
                1: sig = 16'sh7FFF;
                default: sig = shortint'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0) refv = shortint'($urandom);
            else if (neg) refv = shortint'($urandom | 32'h8000);
            else refv = shortint'($urandom & 32'h7FFF);
            send_sample(sig, refv, gapless, fired, res);
            if (fired) mean_q.push_back(res);
            sent++;
        end
        push <= 1'b0;
    endtask

    typedef struct {
        shortint sig;
        shortint refv;
        bit      typed;
        shortint x;
        shortint y;
    } stim_row_t;

    // Window of one pair, output every sample: a four-sample period leaves
    // only its last product pair (sine -1, cosine 0) in the window.
    stim_row_t dir_rows[] = '{
        '{16'sh0000, -16'sd1,      0, 0, 0},
        '{16'sd12345, 16'sh0000,   0, 0, 0},
        '{16'sh7FFF, 16'sh8000,    0, 0, 0},
        '{-16'sd1,   -16'sd5,      0, 0, 0},
        '{16'sd100,  -16'sd1,      0, 0, 0},
        '{16'sh8000, 16'sh7FFF,    1, 16'sd32767, 16'sd0},
        '{16'sd7,    -16'sd2,      1, 16'sd32767, 16'sd0},
        '{16'sh8000, 16'sh8000,    0, 0, 0},
        '{16'sh7FFF, 16'sd1,       0, 0, 0},
        '{16'sh5555, -16'sd1,      0, 0, 0},
        '{16'shAAAA, 16'sh7FFF,    0, 0, 0},
        '{16'sh7FFF, 16'shFFFF,    0, 0, 0},
        '{16'sh8000, 16'sh4000,    0, 0, 0},
        '{16'sh1234, 16'sh8001,    0, 0, 0},
        '{16'shEDCB, 16'sh0001,    0, 0, 0}
    };

    // Result side
    initial begin
        int gap_left;
        pop = 1'b0;
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (mean_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result x=%0d y=%0d", o_x_mean, o_y_mean);
                end else begin
                    if (o_x_mean !== mean_q[0].x || o_y_mean !== mean_q[0].y) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     mean_q[0].x, mean_q[0].y, o_x_mean, o_y_mean);
                    end
                    void'(mean_q.pop_front());
                end
                gap_left = no_stall ? 0 : $urandom_range(0, 12);
            end
            if (hold_rx || gap_left > 0) begin
                pop <= 1'b0;
                if (!hold_rx) gap_left--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Long receiver stall so the block backs up and raises full to the sender
    initial begin
        wait (pressure_go);
        hold_rx = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_rx = 1'b0;
    end

    initial begin
        #40_000_000;
        $display("chopper_lockin_demodulator_top test failed");
        $finish;
    end

    initial begin
        bit         fired;
        mean_pair_t res;
        push         = 1'b0;
        i_sig_sample = '0;
        i_ref_sample = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_PHASE;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        lockin_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_settings(WR_ALL, 0, 1, 1);
        foreach (dir_rows[i]) begin
            send_sample(dir_rows[i].sig, dir_rows[i].refv, 1'b0, fired, res);
            if (dir_rows[i].typed) mean_q.push_back('{dir_rows[i].x, dir_rows[i].y});
            else if (fired) mean_q.push_back(res);
        end
        push <= 1'b0;
        drain();

        apply_settings(WR_ALL, $urandom_range(0, 65535), 1, 1);
        pressure_go = 1'b1;
        random_phase(120, 1'b0, 1'b0);
        drain();

        apply_settings(WR_ALL, 65535, 0, 0);
        random_phase(60, 1'b0, 1'b0);
        drain();

        no_stall = 1'b1;
        apply_settings(WR_ALL, $urandom_range(0, 65535), 7, 3);
        random_phase(80, 1'b1, 1'b1);
        drain();
        no_stall = 1'b0;

        // Park the tick count high, then lower the interval under it
        apply_settings(WR_INTERVAL, 0, 0, 1048575);
        random_phase(40, 1'b0, 1'b0);
        drain();
        apply_settings(WR_INTERVAL, 0, 0, 2);
        random_phase(40, 1'b0, 1'b0);
        drain();

        apply_settings(WR_ALL, $urandom_range(0, 65535), 17'h1FFFF, 5);
        random_phase(30, 1'b0, 1'b0);
        drain();

        apply_settings(WR_ALL, $urandom_range(0, 65535), 33, 4);
        random_phase(100, 1'b0, 1'b0);
        drain();

        apply_settings(WR_ALL, $urandom_range(0, 65535), 1, 2);
        random_phase(40, 1'b0, 1'b0);
        drain();

        if (mismatches == 0 && mean_q.size() == 0) begin
            $display("chopper_lockin_demodulator_top test passed");
        end else begin
            $display("chopper_lockin_demodulator_top test failed");
        end
        $finish;
    end

endmodule
